@@ rtl/b64se_pkg.sv @@
`default_nettype none

package b64se_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;
    localparam logic [1:0] SLOT_FOURTH = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       final_char;
    } t_out;

    typedef struct packed {
        logic [5:0] sym_a;
        logic [5:0] sym_b;
        logic [1:0] last_slot;
        logic       eom;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } t_phase;

    function automatic logic [7:0] sym_to_ascii(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                c = 8'h41 + w;
            end else if (v < 6'd52) begin
                c = 8'h61 + w - 8'd26;
            end else if (v < 6'd62) begin
                c = 8'h30 + w - 8'd52;
            end else if (v == 6'd62) begin
                c = 8'h2B;
            end else begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/b64se_front.sv @@
`default_nettype none

module b64se_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  b64se_pkg::t_in      i_data,
    input  b64se_pkg::t_qstat   i_qstat,
    output logic                o_push,
    output b64se_pkg::t_req     o_req
);

    b64se_pkg::t_phase r_phase, n_phase;
    logic [3:0]        r_left, n_left;
    logic [7:0]        b;
    logic              eom;

    assign b       = i_data.data_byte;
    assign eom     = i_data.end_of_message;
    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    always_comb begin
        o_req.eom = eom;
        n_phase   = r_phase;
        n_left    = r_left;
        case (r_phase)
            b64se_pkg::PH_SECOND: begin
                o_req.sym_a     = {r_left[1:0], b[7:4]};
                o_req.sym_b     = {b[3:0], 2'b00};
                o_req.last_slot = eom ? b64se_pkg::SLOT_THIRD : b64se_pkg::SLOT_FIRST;
                n_left          = b[3:0];
                n_phase         = b64se_pkg::PH_THIRD;
            end
            b64se_pkg::PH_THIRD: begin
                o_req.sym_a     = {r_left, b[7:6]};
                o_req.sym_b     = b[5:0];
                o_req.last_slot = b64se_pkg::SLOT_SECOND;
                n_left          = 4'd0;
                n_phase         = b64se_pkg::PH_FIRST;
            end
            default: begin
                o_req.sym_a     = b[7:2];
                o_req.sym_b     = {b[1:0], 4'b0000};
                o_req.last_slot = eom ? b64se_pkg::SLOT_FOURTH : b64se_pkg::SLOT_FIRST;
                n_left          = {2'b00, b[1:0]};
                n_phase         = b64se_pkg::PH_SECOND;
            end
        endcase
        if (eom) begin
            n_left  = 4'd0;
            n_phase = b64se_pkg::PH_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64se_pkg::PH_FIRST;
            r_left  <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

@@ rtl/b64se_queue.sv @@
`default_nettype none

module b64se_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  b64se_pkg::t_req     i_req,
    input  wire                 i_pop,
    output b64se_pkg::t_req     o_req,
    output b64se_pkg::t_qstat   o_qstat
);

    localparam logic [b64se_pkg::QUEUE_AW-1:0] LAST_PTR =
        b64se_pkg::QUEUE_AW'(b64se_pkg::QUEUE_DEPTH - 1);
    localparam logic [b64se_pkg::QUEUE_CW-1:0] FULL_CNT =
        b64se_pkg::QUEUE_CW'(b64se_pkg::QUEUE_DEPTH);

    b64se_pkg::t_req                 r_mem [b64se_pkg::QUEUE_DEPTH];
    logic [b64se_pkg::QUEUE_AW-1:0]  r_wptr, r_rptr;
    logic [b64se_pkg::QUEUE_CW-1:0]  r_cnt;
    logic                            wr, rd;

    assign o_qstat.full  = (r_cnt == FULL_CNT);
    assign o_qstat.empty = (r_cnt == '0);
    assign wr            = i_push && !o_qstat.full;
    assign rd            = i_pop && !o_qstat.empty;
    assign o_req         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/b64se_back.sv @@
`default_nettype none

module b64se_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  b64se_pkg::t_req     i_req,
    input  b64se_pkg::t_qstat   i_qstat,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output b64se_pkg::t_out     o_data
);

    logic [1:0]           r_slot;
    logic                 r_valid;
    b64se_pkg::t_out      r_out, n_out;
    logic                 load;
    logic                 at_end;

    assign load    = !i_qstat.empty && (!r_valid || i_ready);
    assign at_end  = (r_slot == i_req.last_slot);
    assign o_pop   = load && at_end;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_comb begin
        case (r_slot)
            b64se_pkg::SLOT_FIRST:  n_out.ascii_char = b64se_pkg::sym_to_ascii(i_req.sym_a);
            b64se_pkg::SLOT_SECOND: n_out.ascii_char = b64se_pkg::sym_to_ascii(i_req.sym_b);
            default:                n_out.ascii_char = b64se_pkg::PAD_CHAR;
        endcase
        n_out.final_char = at_end && i_req.eom;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= b64se_pkg::SLOT_FIRST;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_slot  <= at_end ? b64se_pkg::SLOT_FIRST : r_slot + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/base64_stream_encoder_unit.sv @@
// Channel  Valid    Ready    Payload   Moves
// -------  -------  -------  --------  ---------------------------------------
// in       i_valid  o_ready  i_data    one message byte and its end flag
// out      o_valid  i_ready  o_data    one Base64 character and its final flag
//
// Each byte request is classified in the cycle it is accepted and queued as
// one to four characters; unless i_ready holds it back, the output stage sends
// one character per cycle, about 1.33 characters per byte on a long message.
// Input takes a byte every cycle until the two-entry queue is full.
// Reset is synchronous; it empties the queue and starts a new group.
// Each side stalls alone: the output register holds under back-pressure.
`default_nettype none

module base64_stream_encoder_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  b64se_pkg::t_in      i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output b64se_pkg::t_out     o_data
);

    b64se_pkg::t_qstat qstat;
    b64se_pkg::t_req   push_req, head_req;
    logic              push, pop;

    b64se_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_qstat (qstat),
        .o_push  (push),
        .o_req   (push_req)
    );

    b64se_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .i_pop   (pop),
        .o_req   (head_req),
        .o_qstat (qstat)
    );

    b64se_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (head_req),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

@@ tb/b64se_checker.sv @@
`default_nettype none

module b64se_checker
    import b64se_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_in_ready,
    input  t_in   i_in_data,
    input  wire   i_out_valid,
    input  wire   i_out_ready,
    input  t_out  i_out_data,
    output int    o_fail_count,
    output int    o_pending
);

    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    t_out       expected_chars[$];
    t_phase     group_pos;
    logic [3:0] carry_bits;
    int         mismatches;
    t_out       want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
        group_pos    = PH_FIRST;
        carry_bits   = 4'd0;
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        int idx;
        idx = v;
        return B64_ALPHABET[511 - 8 * idx -: 8];
    endfunction

    task automatic queue_char(input t_out c);
        expected_chars.insert(expected_chars.size(), c);
    endtask

    task automatic encode_byte(input t_in req);
        logic [7:0] b;
        logic       eom;
        b   = req.data_byte;
        eom = req.end_of_message;
        case (group_pos)
            PH_SECOND: begin
                queue_char({b64_char({carry_bits[1:0], b[7:4]}), 1'b0});
                if (eom) begin
                    queue_char({b64_char({b[3:0], 2'b00}), 1'b0});
                    queue_char({PAD_CHAR, 1'b1});
                end else begin
                    carry_bits = b[3:0];
                    group_pos  = PH_THIRD;
                end
            end
            PH_THIRD: begin
                queue_char({b64_char({carry_bits, b[7:6]}), 1'b0});
                queue_char({b64_char(b[5:0]), eom});
                carry_bits = 4'd0;
                group_pos  = PH_FIRST;
            end
            default: begin
                queue_char({b64_char(b[7:2]), 1'b0});
                if (eom) begin
                    queue_char({b64_char({b[1:0], 4'b0000}), 1'b0});
                    queue_char({PAD_CHAR, 1'b0});
                    queue_char({PAD_CHAR, 1'b1});
                end else begin
                    carry_bits = {2'b00, b[1:0]};
                    group_pos  = PH_SECOND;
                end
            end
        endcase
        if (eom) begin
            carry_bits = 4'd0;
            group_pos  = PH_FIRST;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_chars.delete();
            carry_bits = 4'd0;
            group_pos  = PH_FIRST;
        end else begin
            if (i_in_valid && i_in_ready) begin
                encode_byte(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected char %h final %b at %0t",
                                 i_out_data.ascii_char, i_out_data.final_char, $realtime);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (want.ascii_char !== i_out_data.ascii_char ||
                        want.final_char !== i_out_data.final_char) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("char mismatch at %0t: exp %h/%b got %h/%b",
                                     $realtime, want.ascii_char, want.final_char,
                                     i_out_data.ascii_char, i_out_data.final_char);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_chars.size();
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;

    import b64se_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic in_valid   = 1'b0;
    t_in  in_data    = '0;
    logic out_ready  = 1'b0;
    logic stall_req  = 1'b0;
    logic o_ready;
    logic o_valid;
    t_out o_data;
    int   fail_count;
    int   pending;
    int   send_idle  = 0;
    int   recv_idle  = 0;
    int   idle_cycles = 0;

    base64_stream_encoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (o_ready),
        .i_data  (in_data),
        .o_valid (o_valid),
        .i_ready (out_ready),
        .o_data  (o_data)
    );

    b64se_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (in_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req <= 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((in_valid && o_ready) || (o_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, end_of_message: eom};
        do begin
            @(posedge i_clk);
        end while (!o_ready);
    endtask

    task automatic drain_chars();
        in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    task automatic send_message(input int len);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) begin
                b = $urandom_range(1) ? 8'hFF : 8'h00;
            end else begin
                b = 8'($urandom_range(255));
            end
            send_byte(b, k == len - 1);
        end
    endtask

    initial begin
        int sent;
        int len;
        bit stalled;
        stalled = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h66, 1'b0);
        send_byte(8'h6F, 1'b0);
        send_byte(8'h6F, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h72, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h7F, 1'b1);
        drain_chars();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle = 28;
                    recv_idle = 78;
                end
                1: begin
                    send_idle = 78;
                    recv_idle = 28;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            sent = 0;
            while (sent < 100) begin
                if (ph == 2 && sent >= 40 && !stalled) begin
                    stalled = 1'b1;
                    stall_req <= 1'b1;
                end
                len = ($urandom_range(3) == 0) ? $urandom_range(40, 13)
                                               : $urandom_range(12, 1);
                send_message(len);
                sent += len;
            end
            drain_chars();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
